@@ rtl/core/ecfr_pkg.sv @@
`default_nettype none

package ecfr_pkg;

    localparam logic [7:0]  DELIM     = 8'h7E;
    localparam logic [7:0]  ESC       = 8'h7D;
    localparam logic [7:0]  XON       = 8'h11;
    localparam logic [7:0]  XOFF      = 8'h13;
    localparam logic [7:0]  ESC_XOR   = 8'h20;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h8408;
    localparam logic [15:0] TICKS_MAX = 16'hFFFF;

    localparam logic [7:0]  MAX_PAYLOAD_RST = 8'd255;
    localparam logic [15:0] TIMEOUT_RST     = 16'd1000;
    localparam logic [7:0]  FLAG_XORED_RST  = 8'd1;
    localparam logic [7:0]  FLAG_PLAIN_RST  = 8'd0;

    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        REG_MAX_PAYLOAD = 2'd0,
        REG_TIMEOUT_MS  = 2'd1,
        REG_FLAG_XORED  = 2'd2,
        REG_FLAG_PLAIN  = 2'd3
    } reg_index_t;

    typedef enum logic [3:0] {
        KIND_PAYLOAD     = 4'd0,
        KIND_FRAME_OK    = 4'd1,
        KIND_STRAY_DELIM = 4'd2,
        KIND_STRAY_XONOF = 4'd3,
        KIND_BAD_FLAG    = 4'd4,
        KIND_HDR_CRC     = 4'd5,
        KIND_PAY_CRC     = 4'd6,
        KIND_OVERSIZE    = 4'd7,
        KIND_UART_ERR    = 4'd8,
        KIND_TIMEOUT     = 4'd9
    } kind_t;

    typedef enum logic [3:0] {
        ST_HUNT        = 4'd0,
        ST_FLAG        = 4'd1,
        ST_LEN         = 4'd2,
        ST_HCRC_HI     = 4'd3,
        ST_HCRC_HI_ESC = 4'd4,
        ST_HCRC_LO     = 4'd5,
        ST_HCRC_LO_ESC = 4'd6,
        ST_PAY         = 4'd7,
        ST_PAY_ESC     = 4'd8,
        ST_PCRC_HI     = 4'd9,
        ST_PCRC_HI_ESC = 4'd10,
        ST_PCRC_LO     = 4'd11,
        ST_PCRC_LO_ESC = 4'd12
    } frame_state_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
        logic       rx_error;
    } item_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [7:0] count;
        logic       last;
    } result_t;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/escaped_crc_frame_receiver.sv @@
`default_nettype none

// Byte-stuffed frame receiver with CRC-16 (reflected CCITT, init 0xFFFF).
// Each item (a UART byte or a 1 ms tick) is decoded in the cycle it is
// accepted and its results, zero to two, go into a four-entry result queue.
// An item is taken every cycle as long as the queue has room for two results;
// one result leaves per cycle while result_ready is high, so an item that
// yields a payload byte and an oversize result needs two transfers. Results
// are queued before the result port; configuration writes are registered.
module escaped_crc_frame_receiver (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        item_valid,
    output logic                       item_ready,
    input  wire ecfr_pkg::item_t       item,
    output logic                       result_valid,
    input  wire                        result_ready,
    output ecfr_pkg::result_t          result,
    input  wire                        wr_en,
    input  wire [1:0]                  wr_index,
    input  wire [ecfr_pkg::CFG_DATA_W-1:0] wr_data
);
    import ecfr_pkg::*;

    logic [7:0]   max_payload_reg;
    logic [15:0]  timeout_ms_reg;
    logic [7:0]   flag_xored_reg;
    logic [7:0]   flag_plain_reg;

    frame_state_t state_reg, state_next;
    logic [15:0]  crc_reg, crc_next;
    logic [15:0]  elapsed_reg, elapsed_next;
    logic         xored_reg, xored_next;
    logic [7:0]   slen_reg, slen_next;
    logic [7:0]   sbr_reg, sbr_next;
    logic [7:0]   pc_reg, pc_next;

    logic         emit;
    logic [7:0]   emit_data;
    logic         fin;
    kind_t        fin_kind;
    logic [7:0]   pc_inc;

    result_t      res0, res1;
    logic [1:0]   nres;

    result_t      queue_reg [4];
    logic [1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [2:0]   cnt_reg;
    logic         take, give;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            max_payload_reg <= MAX_PAYLOAD_RST;
            timeout_ms_reg  <= TIMEOUT_RST;
            flag_xored_reg  <= FLAG_XORED_RST;
            flag_plain_reg  <= FLAG_PLAIN_RST;
        end
        else if (wr_en) begin
            unique case (reg_index_t'(wr_index))
                REG_MAX_PAYLOAD: max_payload_reg <= wr_data[7:0];
                REG_TIMEOUT_MS:  timeout_ms_reg  <= wr_data[15:0];
                REG_FLAG_XORED:  flag_xored_reg  <= wr_data[7:0];
                REG_FLAG_PLAIN:  flag_plain_reg  <= wr_data[7:0];
                default:         ;
            endcase
        end
    end

    assign take   = item_valid && item_ready;
    assign give   = result_valid && result_ready;
    assign pc_inc = pc_reg + 8'd1;

    // next state
    always_comb begin
        logic [7:0]  b;
        logic [7:0]  bu;
        logic [15:0] tick_cnt;
        logic [7:0]  sbr_inc;
        logic        counted;

        b        = item.rx_byte;
        bu       = b ^ ESC_XOR;
        tick_cnt = (elapsed_reg != TICKS_MAX) ? elapsed_reg + 16'd1 : elapsed_reg;
        sbr_inc  = sbr_reg + 8'd1;
        counted  = 1'b0;

        state_next   = state_reg;
        crc_next     = crc_reg;
        elapsed_next = elapsed_reg;
        xored_next   = xored_reg;
        slen_next    = slen_reg;
        sbr_next     = sbr_reg;
        pc_next      = pc_reg;
        emit         = 1'b0;
        emit_data    = b;
        fin          = 1'b0;
        fin_kind     = KIND_FRAME_OK;

        if (item.mode) begin
            elapsed_next = tick_cnt;
            if (tick_cnt >= timeout_ms_reg) begin
                fin      = 1'b1;
                fin_kind = KIND_TIMEOUT;
            end
        end
        else if (elapsed_reg >= timeout_ms_reg) begin
            fin      = 1'b1;
            fin_kind = KIND_TIMEOUT;
        end
        else if (item.rx_error) begin
            fin      = 1'b1;
            fin_kind = KIND_UART_ERR;
        end
        else if (state_reg != ST_HUNT && b == DELIM) begin
            fin      = 1'b1;
            fin_kind = KIND_STRAY_DELIM;
        end
        else if (state_reg != ST_HUNT && (b == XON || b == XOFF)) begin
            fin      = 1'b1;
            fin_kind = KIND_STRAY_XONOF;
        end
        else begin
            unique case (state_reg)
                ST_HUNT: begin
                    if (b == DELIM) begin
                        crc_next   = crc_step(crc_reg, b);
                        state_next = ST_FLAG;
                    end
                end
                ST_FLAG: begin
                    crc_next   = crc_step(crc_reg, b);
                    state_next = ST_LEN;
                    priority if (b == flag_xored_reg) begin
                        xored_next = 1'b1;
                    end
                    else if (b == flag_plain_reg) begin
                        xored_next = 1'b0;
                    end
                    else begin
                        fin      = 1'b1;
                        fin_kind = KIND_BAD_FLAG;
                    end
                end
                ST_LEN: begin
                    crc_next   = crc_step(crc_reg, b);
                    slen_next  = xored_reg ? bu : b;
                    state_next = ST_HCRC_HI;
                end
                ST_HCRC_HI, ST_PCRC_HI: begin
                    if (b == ESC) begin
                        state_next = (state_reg == ST_HCRC_HI) ? ST_HCRC_HI_ESC
                                                               : ST_PCRC_HI_ESC;
                    end
                    else if (b != crc_reg[15:8]) begin
                        fin      = 1'b1;
                        fin_kind = (state_reg == ST_HCRC_HI) ? KIND_HDR_CRC : KIND_PAY_CRC;
                    end
                    else begin
                        state_next = (state_reg == ST_HCRC_HI) ? ST_HCRC_LO : ST_PCRC_LO;
                    end
                end
                ST_HCRC_HI_ESC, ST_PCRC_HI_ESC: begin
                    if (bu != crc_reg[15:8]) begin
                        fin      = 1'b1;
                        fin_kind = (state_reg == ST_HCRC_HI_ESC) ? KIND_HDR_CRC
                                                                 : KIND_PAY_CRC;
                    end
                    else begin
                        state_next = (state_reg == ST_HCRC_HI_ESC) ? ST_HCRC_LO
                                                                   : ST_PCRC_LO;
                    end
                end
                ST_HCRC_LO, ST_HCRC_LO_ESC: begin
                    if (state_reg == ST_HCRC_LO && b == ESC) begin
                        state_next = ST_HCRC_LO_ESC;
                    end
                    else if (((state_reg == ST_HCRC_LO_ESC) ? bu : b) != crc_reg[7:0]) begin
                        fin      = 1'b1;
                        fin_kind = KIND_HDR_CRC;
                    end
                    else begin
                        crc_next   = CRC_INIT;
                        state_next = (slen_reg != 8'd0) ? ST_PAY : ST_PCRC_HI;
                    end
                end
                ST_PCRC_LO, ST_PCRC_LO_ESC: begin
                    fin = 1'b1;
                    if (state_reg == ST_PCRC_LO && b == ESC) begin
                        fin        = 1'b0;
                        state_next = ST_PCRC_LO_ESC;
                    end
                    else if (((state_reg == ST_PCRC_LO_ESC) ? bu : b) != crc_reg[7:0]) begin
                        fin_kind = KIND_PAY_CRC;
                    end
                    else begin
                        fin_kind = KIND_FRAME_OK;
                    end
                end
                ST_PAY, ST_PAY_ESC: begin
                    crc_next = crc_step(crc_reg, b);
                    sbr_next = sbr_inc;
                    if (state_reg == ST_PAY && b == ESC) begin
                        state_next = ST_PAY_ESC;
                    end
                    else begin
                        counted    = 1'b1;
                        pc_next    = pc_inc;
                        emit       = 1'b1;
                        emit_data  = (state_reg == ST_PAY_ESC) ? bu : b;
                        state_next = ST_PAY;
                    end
                    if (sbr_inc == slen_reg) begin
                        state_next = ST_PCRC_HI;
                    end
                    else if ((counted ? pc_inc : pc_reg) >= max_payload_reg) begin
                        fin      = 1'b1;
                        fin_kind = KIND_OVERSIZE;
                    end
                end
                default: begin
                    state_next = ST_HUNT;
                end
            endcase
        end

        if (fin || state_reg > ST_PCRC_LO_ESC) begin
            state_next   = ST_HUNT;
            crc_next     = CRC_INIT;
            elapsed_next = 16'd0;
            xored_next   = 1'b0;
            slen_next    = 8'd0;
            sbr_next     = 8'd0;
            pc_next      = 8'd0;
        end
    end

    // results of the item
    always_comb begin
        logic [7:0] fin_count;
        fin_count = emit ? pc_inc : pc_reg;

        res0.kind  = KIND_PAYLOAD;
        res0.data  = emit_data;
        res0.count = pc_inc;
        res0.last  = !fin;

        res1.kind  = fin_kind;
        res1.data  = 8'd0;
        res1.count = fin_count;
        res1.last  = 1'b1;
        nres       = {1'b0, emit} + {1'b0, fin};

        if (!emit) begin
            res0 = res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg   <= ST_HUNT;
            crc_reg     <= CRC_INIT;
            elapsed_reg <= 16'd0;
            xored_reg   <= 1'b0;
            slen_reg    <= 8'd0;
            sbr_reg     <= 8'd0;
            pc_reg      <= 8'd0;
        end
        else if (take) begin
            state_reg   <= state_next;
            crc_reg     <= crc_next;
            elapsed_reg <= elapsed_next;
            xored_reg   <= xored_next;
            slen_reg    <= slen_next;
            sbr_reg     <= sbr_next;
            pc_reg      <= pc_next;
        end
    end

    assign item_ready   = (cnt_reg <= 3'd2);
    assign result_valid = (cnt_reg != 3'd0);
    assign result       = queue_reg[rd_ptr_reg];

    always_ff @(posedge clk) begin
        if (take && nres != 2'd0) begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (take && nres == 2'd2) begin
            queue_reg[wr_ptr_reg + 2'd1] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            cnt_reg    <= 3'd0;
        end
        else begin
            if (take) begin
                wr_ptr_reg <= wr_ptr_reg + nres;
            end
            if (give) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + (take ? {1'b0, nres} : 3'd0) - {2'b00, give};
        end
    end

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ecfr_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int LOG_LIMIT    = 40;

    typedef enum int {
        FAULT_NONE,
        FAULT_HDR_CRC,
        FAULT_PAY_CRC,
        FAULT_BAD_FLAG,
        FAULT_STRAY_DELIM,
        FAULT_STRAY_XON,
        FAULT_UART_ERR,
        FAULT_CUT_SHORT
    } fault_t;

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    logic                  item_ready;
    item_t                 item         = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    result_t               result;
    logic                  wr_en        = 1'b0;
    logic [1:0]            wr_index     = '0;
    logic [CFG_DATA_W-1:0] wr_data      = '0;

    escaped_crc_frame_receiver uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    // deframer configuration as the block holds it
    logic [7:0]   cfg_max_payload = MAX_PAYLOAD_RST;
    logic [15:0]  cfg_timeout     = TIMEOUT_RST;
    logic [7:0]   cfg_flag_xor    = FLAG_XORED_RST;
    logic [7:0]   cfg_flag_plain  = FLAG_PLAIN_RST;

    // deframer state
    frame_state_t rx_state     = ST_HUNT;
    logic [15:0]  rx_fcs       = CRC_INIT;
    logic [15:0]  tick_count   = '0;
    logic         len_xored    = 1'b0;
    logic [7:0]   stuffed_len  = '0;
    logic [7:0]   stuffed_seen = '0;
    logic [7:0]   pay_count    = '0;

    result_t      step_out[$];
    result_t      pending_results[$];
    item_t        tx_frame[$];
    logic [7:0]   pay_bytes[$];

    int           errors          = 0;
    int           items_sent      = 0;
    int           results_checked = 0;
    int           settings_used   = 1;
    int           idle_cycles     = 0;
    int           hold_off_left   = 0;
    int           tick_percent    = 0;
    bit           no_idle         = 1'b0;
    int           kind_hits[10];

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [15:0] fcs_update(input logic [15:0] fcs, input logic [7:0] b);
        logic [15:0] acc;
        acc = fcs ^ {8'h00, b};
        repeat (8) acc = (acc >> 1) ^ (acc[0] ? CRC_POLY : 16'h0000);
        return acc;
    endfunction

    function automatic bit is_special(input logic [7:0] b);
        return b == DELIM || b == ESC || b == XON || b == XOFF;
    endfunction

    function automatic void restart_hunt();
        rx_state     = ST_HUNT;
        rx_fcs       = CRC_INIT;
        tick_count   = '0;
        len_xored    = 1'b0;
        stuffed_len  = '0;
        stuffed_seen = '0;
        pay_count    = '0;
    endfunction

    function automatic void emit(input kind_t k, input logic [7:0] d);
        result_t r;
        r.kind  = k;
        r.data  = d;
        r.count = pay_count;
        r.last  = 1'b0;
        step_out.push_back(r);
    endfunction

    function automatic void end_frame(input kind_t k);
        emit(k, 8'h00);
        restart_hunt();
    endfunction

    function automatic void count_stuffed();
        stuffed_seen = stuffed_seen + 8'd1;
        if (stuffed_seen == stuffed_len)
            rx_state = ST_PCRC_HI;
        else if (pay_count >= cfg_max_payload)
            end_frame(KIND_OVERSIZE);
    endfunction

    function automatic void decode_item(input item_t it);
        logic [7:0] b;
        logic [7:0] want_hi;
        logic [7:0] want_lo;
        b = it.rx_byte;
        if (it.mode) begin
            if (tick_count != TICKS_MAX)
                tick_count = tick_count + 16'd1;
            if (tick_count >= cfg_timeout)
                end_frame(KIND_TIMEOUT);
            return;
        end
        if (tick_count >= cfg_timeout) begin
            end_frame(KIND_TIMEOUT);
            return;
        end
        if (it.rx_error) begin
            end_frame(KIND_UART_ERR);
            return;
        end
        if (rx_state != ST_HUNT) begin
            if (b == DELIM) begin
                end_frame(KIND_STRAY_DELIM);
                return;
            end
            if (b == XON || b == XOFF) begin
                end_frame(KIND_STRAY_XONOF);
                return;
            end
        end
        want_hi = rx_fcs[15:8];
        want_lo = rx_fcs[7:0];
        case (rx_state)
            ST_HUNT: begin
                if (b == DELIM) begin
                    rx_fcs   = fcs_update(rx_fcs, b);
                    rx_state = ST_FLAG;
                end
            end
            ST_FLAG: begin
                rx_fcs = fcs_update(rx_fcs, b);
                if (b == cfg_flag_xor)
                    len_xored = 1'b1;
                else if (b == cfg_flag_plain)
                    len_xored = 1'b0;
                else begin
                    end_frame(KIND_BAD_FLAG);
                    return;
                end
                rx_state = ST_LEN;
            end
            ST_LEN: begin
                rx_fcs      = fcs_update(rx_fcs, b);
                stuffed_len = len_xored ? (b ^ ESC_XOR) : b;
                rx_state    = ST_HCRC_HI;
            end
            ST_HCRC_HI, ST_HCRC_HI_ESC: begin
                if (rx_state == ST_HCRC_HI && b == ESC)
                    rx_state = ST_HCRC_HI_ESC;
                else begin
                    if (rx_state == ST_HCRC_HI_ESC)
                        b = b ^ ESC_XOR;
                    if (b != want_hi)
                        end_frame(KIND_HDR_CRC);
                    else
                        rx_state = ST_HCRC_LO;
                end
            end
            ST_HCRC_LO, ST_HCRC_LO_ESC: begin
                if (rx_state == ST_HCRC_LO && b == ESC)
                    rx_state = ST_HCRC_LO_ESC;
                else begin
                    if (rx_state == ST_HCRC_LO_ESC)
                        b = b ^ ESC_XOR;
                    if (b != want_lo)
                        end_frame(KIND_HDR_CRC);
                    else begin
                        rx_fcs   = CRC_INIT;
                        rx_state = (stuffed_len > 8'd0) ? ST_PAY : ST_PCRC_HI;
                    end
                end
            end
            ST_PAY: begin
                rx_fcs = fcs_update(rx_fcs, b);
                if (b == ESC)
                    rx_state = ST_PAY_ESC;
                else begin
                    pay_count = pay_count + 8'd1;
                    emit(KIND_PAYLOAD, b);
                end
                count_stuffed();
            end
            ST_PAY_ESC: begin
                rx_fcs    = fcs_update(rx_fcs, b);
                pay_count = pay_count + 8'd1;
                emit(KIND_PAYLOAD, b ^ ESC_XOR);
                rx_state  = ST_PAY;
                count_stuffed();
            end
            ST_PCRC_HI, ST_PCRC_HI_ESC: begin
                if (rx_state == ST_PCRC_HI && b == ESC)
                    rx_state = ST_PCRC_HI_ESC;
                else begin
                    if (rx_state == ST_PCRC_HI_ESC)
                        b = b ^ ESC_XOR;
                    if (b != want_hi)
                        end_frame(KIND_PAY_CRC);
                    else
                        rx_state = ST_PCRC_LO;
                end
            end
            ST_PCRC_LO, ST_PCRC_LO_ESC: begin
                if (rx_state == ST_PCRC_LO && b == ESC)
                    rx_state = ST_PCRC_LO_ESC;
                else begin
                    if (rx_state == ST_PCRC_LO_ESC)
                        b = b ^ ESC_XOR;
                    if (b != want_lo)
                        end_frame(KIND_PAY_CRC);
                    else
                        end_frame(KIND_FRAME_OK);
                end
            end
            default: restart_hunt();
        endcase
    endfunction

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            errors++;
            if (errors <= LOG_LIMIT)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // check result transfers, then predict from item transfers
    always @(posedge clk) begin : monitor
        result_t want;
        if (rst_n) begin
            if (result_valid && result_ready) begin
                results_checked++;
                if (int'(result.kind) < 10)
                    kind_hits[int'(result.kind)]++;
                if (pending_results.size() == 0) begin
                    errors++;
                    if (errors <= LOG_LIMIT)
                        $display("%0t: expected none, actual kind %0d data %0d count %0d last %0d",
                                 $time, result.kind, result.data, result.count, result.last);
                end else begin
                    want = pending_results.pop_front();
                    check_field("kind", int'(want.kind), int'(result.kind));
                    check_field("data", int'(want.data), int'(result.data));
                    check_field("count", int'(want.count), int'(result.count));
                    check_field("last", int'(want.last), int'(result.last));
                end
            end
            if (item_valid && item_ready) begin
                step_out.delete();
                decode_item(item);
                if (step_out.size() > 0)
                    step_out[step_out.size() - 1].last = 1'b1;
                foreach (step_out[i])
                    pending_results.push_back(step_out[i]);
            end
            if ((result_valid && result_ready) || (item_valid && item_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    initial begin : watchdog
        wait (idle_cycles >= IDLE_LIMIT);
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, IDLE_LIMIT, pending_results.size());
        $display("tb_top failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial begin : receiver
        int wait_left;
        wait_left = 0;
        forever begin
            @(posedge clk);
            if (hold_off_left > 0) begin
                result_ready <= 1'b0;
                hold_off_left--;
            end else if (no_idle) begin
                result_ready <= 1'b1;
            end else if (wait_left > 0) begin
                result_ready <= 1'b0;
                wait_left--;
            end else begin
                wait_left = pick_gap();
                result_ready <= (wait_left == 0);
            end
        end
    end

    task automatic send_item(input item_t it);
        int gap;
        gap = pick_gap();
        wr_en <= 1'b0;
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item('{mode: 1'b0, rx_byte: b, rx_error: 1'b0});
    endtask

    function automatic item_t tick_item();
        return '{mode: 1'b1, rx_byte: 8'($urandom), rx_error: 1'($urandom)};
    endfunction

    function automatic item_t noise_item();
        return '{mode: ($urandom_range(0, 7) == 0), rx_byte: 8'($urandom),
                 rx_error: ($urandom_range(0, 15) == 0)};
    endfunction

    // drop valid, wait until every expected result has arrived, then let the block go quiet
    task automatic settle();
        item_valid <= 1'b0;
        wr_en <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [15:0] value);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= value;
        @(posedge clk);
        case (idx)
            REG_MAX_PAYLOAD: cfg_max_payload = value[7:0];
            REG_TIMEOUT_MS:  cfg_timeout     = value;
            REG_FLAG_XORED:  cfg_flag_xor    = value[7:0];
            REG_FLAG_PLAIN:  cfg_flag_plain  = value[7:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [7:0] max_pay, input logic [15:0] tmo,
                             input logic [7:0] fx, input logic [7:0] fp);
        settle();
        write_reg(REG_MAX_PAYLOAD, {8'h00, max_pay});
        write_reg(REG_TIMEOUT_MS, tmo);
        write_reg(REG_FLAG_XORED, {8'h00, fx});
        write_reg(REG_FLAG_PLAIN, {8'h00, fp});
        settings_used++;
    endtask

    function automatic void push_raw(input logic [7:0] b);
        tx_frame.push_back('{mode: 1'b0, rx_byte: b, rx_error: 1'b0});
    endfunction

    function automatic void push_stuffed(input logic [7:0] b);
        if (is_special(b)) begin
            push_raw(ESC);
            push_raw(b ^ ESC_XOR);
        end else
            push_raw(b);
    endfunction

    task automatic build_frame(input bit xored, input fault_t fault);
        logic [7:0]  stuffed[$];
        logic [7:0]  flag_byte;
        logic [7:0]  len_byte;
        logic [15:0] hdr_fcs;
        logic [15:0] pay_fcs;
        int          idx;
        foreach (pay_bytes[i]) begin
            if (is_special(pay_bytes[i])) begin
                stuffed.push_back(ESC);
                stuffed.push_back(pay_bytes[i] ^ ESC_XOR);
            end else
                stuffed.push_back(pay_bytes[i]);
        end
        while (stuffed.size() > 255) void'(stuffed.pop_back());
        flag_byte = xored ? cfg_flag_xor : cfg_flag_plain;
        if (fault == FAULT_BAD_FLAG) begin
            flag_byte = 8'($urandom);
            while (flag_byte == cfg_flag_xor || flag_byte == cfg_flag_plain)
                flag_byte = 8'($urandom);
        end
        len_byte = 8'(stuffed.size());
        if (xored)
            len_byte = len_byte ^ ESC_XOR;
        hdr_fcs = fcs_update(fcs_update(fcs_update(CRC_INIT, DELIM), flag_byte), len_byte);
        pay_fcs = CRC_INIT;
        foreach (stuffed[i])
            pay_fcs = fcs_update(pay_fcs, stuffed[i]);
        if (fault == FAULT_HDR_CRC)
            hdr_fcs = hdr_fcs ^ 16'($urandom_range(1, 65535));
        if (fault == FAULT_PAY_CRC)
            pay_fcs = pay_fcs ^ 16'($urandom_range(1, 65535));
        tx_frame.delete();
        push_raw(DELIM);
        push_raw(flag_byte);
        push_raw(len_byte);
        push_stuffed(hdr_fcs[15:8]);
        push_stuffed(hdr_fcs[7:0]);
        foreach (stuffed[i])
            push_raw(stuffed[i]);
        push_stuffed(pay_fcs[15:8]);
        push_stuffed(pay_fcs[7:0]);
        idx = $urandom_range(1, tx_frame.size() - 1);
        case (fault)
            FAULT_STRAY_DELIM: tx_frame[idx].rx_byte = DELIM;
            FAULT_STRAY_XON: begin
                // prefer the byte right after an escape
                for (int i = 1; i + 1 < tx_frame.size(); i++)
                    if (tx_frame[i].rx_byte == ESC && $urandom_range(0, 1) == 1)
                        idx = i + 1;
                tx_frame[idx].rx_byte = ($urandom_range(0, 1) == 1) ? XON : XOFF;
            end
            FAULT_UART_ERR: tx_frame[idx].rx_error = 1'b1;
            FAULT_CUT_SHORT: while (tx_frame.size() > idx) void'(tx_frame.pop_back());
            default: ;
        endcase
    endtask

    task automatic send_frame();
        foreach (tx_frame[i]) begin
            if ($urandom_range(0, 99) < tick_percent)
                send_item(tick_item());
            send_item(tx_frame[i]);
        end
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 11))
            0:       return DELIM;
            1:       return ESC;
            2:       return XON;
            3:       return XOFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic make_payload();
        int n;
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            n = $urandom_range(0, 8);
        else if (r < 95)
            n = $urandom_range(9, 24);
        else
            n = $urandom_range(40, 80);
        pay_bytes.delete();
        repeat (n) pay_bytes.push_back(pick_byte());
    endtask

    task automatic send_random_frame();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            repeat ($urandom_range(1, 5)) send_item(noise_item());
        end else begin
            make_payload();
            build_frame(1'($urandom_range(0, 1)),
                        (r < 70) ? FAULT_NONE : fault_t'($urandom_range(1, FAULT_CUT_SHORT)));
            send_frame();
        end
    endtask

    task automatic run_random(input int n);
        int start;
        start = items_sent;
        while (items_sent - start < n) send_random_frame();
    endtask

    task automatic test_directed();
        tick_percent = 0;
        send_item('{mode: 1'b0, rx_byte: DELIM, rx_error: 1'b1});
        send_byte(8'hFF);
        send_item('{mode: 1'b1, rx_byte: 8'h00, rx_error: 1'b1});
        // empty payload: payload crc right after header crc
        pay_bytes.delete();
        build_frame(1'b0, FAULT_NONE);
        send_frame();
        pay_bytes = '{DELIM, ESC};
        build_frame(1'b1, FAULT_NONE);
        send_frame();
        // xon right after an escape in the header crc
        send_byte(DELIM);
        send_byte(FLAG_PLAIN_RST);
        send_byte(8'h00);
        send_byte(ESC);
        send_byte(XON);
        send_byte(DELIM);
        send_byte(DELIM);
        send_byte(DELIM);
        send_byte(8'h05);
    endtask

    task automatic test_random_traffic();
        tick_percent = 5;
        run_random(70);
        no_idle = 1'b1;
        run_random(40);
        no_idle = 1'b0;
    endtask

    task automatic test_oversize();
        configure(8'd2, TIMEOUT_RST, FLAG_XORED_RST, FLAG_PLAIN_RST);
        pay_bytes = '{8'h41, 8'h42};
        build_frame(1'b0, FAULT_NONE);
        send_frame();
        pay_bytes = '{8'h41, 8'h42, 8'h43};
        build_frame(1'b1, FAULT_NONE);
        send_frame();
        run_random(30);
        configure(8'd0, TIMEOUT_RST, FLAG_XORED_RST, FLAG_PLAIN_RST);
        run_random(30);
    endtask

    task automatic test_timeout();
        configure(8'd255, TIMEOUT_RST, FLAG_XORED_RST, FLAG_PLAIN_RST);
        repeat (6) send_item(tick_item());
        send_byte(8'h00);
        // lower the limit below the ticks already counted
        configure(8'd255, 16'd3, FLAG_XORED_RST, FLAG_PLAIN_RST);
        send_byte(8'h00);
        tick_percent = 25;
        run_random(40);
        configure(8'd255, 16'd0, FLAG_XORED_RST, FLAG_PLAIN_RST);
        run_random(25);
        configure(8'd255, 16'hFFFF, FLAG_XORED_RST, FLAG_PLAIN_RST);
        run_random(25);
        tick_percent = 5;
    endtask

    task automatic test_flag_values();
        configure(8'd255, TIMEOUT_RST, 8'hFF, 8'h00);
        run_random(40);
        configure(8'd255, TIMEOUT_RST, 8'h42, 8'h42);
        run_random(40);
        configure(8'd200, 16'd500, 8'h00, 8'hFF);
        run_random(40);
    endtask

    task automatic test_backpressure();
        hold_off_left = 300;
        no_idle = 1'b1;
        pay_bytes.delete();
        repeat (12) pay_bytes.push_back(8'($urandom_range(32, 120)));
        build_frame(1'b0, FAULT_NONE);
        send_frame();
        run_random(30);
        no_idle = 1'b0;
    endtask

    initial begin : main
        int kinds_seen;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_traffic();
        test_oversize();
        test_timeout();
        test_flag_values();
        test_backpressure();
        settle();
        kinds_seen = 0;
        foreach (kind_hits[i])
            if (kind_hits[i] > 0)
                kinds_seen++;
        $display("sent %0d items under %0d register settings, checked %0d results",
                 items_sent, settings_used, results_checked);
        $display("result kinds seen: %0d of 10, frames ok: %0d, payload bytes: %0d",
                 kinds_seen, kind_hits[KIND_FRAME_OK], kind_hits[KIND_PAYLOAD]);
        if (errors == 0 && pending_results.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/core/ecfr_pkg.sv
rtl/core/escaped_crc_frame_receiver.sv
test/tb_top.sv
